// File: hdl/sbrc_pkg.sv
// ----------------------------------------------------------------------------
// sbrc_pkg
// Shared types and constants for the sorted block reference counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrc_pkg;

  localparam int KEY_W           = 64;
  localparam int CNT_W           = 32;
  localparam int POS_W           = 10;
  localparam int TOTAL_W         = 11;
  localparam int POS_MAX         = 1023;
  localparam int TOTAL_MAX       = 2047;
  localparam int DEF_TABLE_DEPTH = 1024;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             compare;
    logic             bump;
    logic             insert;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/sorted_block_reference_counter.sv
// ----------------------------------------------------------------------------
// sorted_block_reference_counter
// Sorted table of block addresses with reference counts, held in a row of
// cells that compare in parallel and shift up on insert.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  item in   start, busy          operation, lba
//  result    done (one cycle)     found, use_count, position, entry_total,
//                                 table_full
//
//  An item passes from accept through the compare state and the registers
//  of the OR tree that collects the boundary cell to done. busy drops in the
//  cycle done is shown, so the next item may start there. rst clears the
//  table (all cells invalid) at once.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_block_reference_counter
  import sbrc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [KEY_W-1:0]   lba,
  output logic                    done,
  output logic                    found,
  output logic [CNT_W-1:0]        use_count,
  output logic [POS_W-1:0]        position,
  output logic [TOTAL_W-1:0]      entry_total,
  output logic                    table_full
);

  localparam int N  = TABLE_DEPTH;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int NW = 2 + CNT_W + AW;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_TREE} state_t;

  state_t           state;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    used;
  logic             tree_go;

  cell_cmd_t        cmd;

  logic [KEY_W-1:0] c_key   [N];
  logic [CNT_W-1:0] c_cnt   [N];
  logic             c_valid [N];
  logic             c_lt    [N];
  logic             c_hit   [N];
  logic             c_eq    [N];
  logic [NW-1:0]    leaf    [N];

  logic             t_valid;
  logic [NW-1:0]    t_root;
  logic             r_hit;
  logic             r_found;
  logic [CNT_W-1:0] r_cnt;
  logic [AW-1:0]    r_idx;

  logic             is_full;
  logic             do_bump;
  logic             do_insert;
  logic [CW-1:0]    used_next;
  logic [CW-1:0]    pos_full;
  logic [CNT_W-1:0] cnt_res;

  assign {r_hit, r_found, r_cnt, r_idx} = t_root;

  assign is_full   = (used == CW'(N));
  assign do_bump   = t_valid && (state == S_TREE) && (op_q == OP_ADD) && r_found;
  assign do_insert = t_valid && (state == S_TREE) && (op_q == OP_ADD) && !r_found
                     && !is_full;
  assign used_next = do_insert ? used + 1'b1 : used;
  assign pos_full  = r_hit ? CW'(r_idx) : used;

  always_comb begin
    if (op_q == OP_LOOKUP) begin
      cnt_res = r_found ? r_cnt : '0;
    end else if (r_found) begin
      cnt_res = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    end else if (is_full) begin
      cnt_res = '0;
    end else begin
      cnt_res = CNT_W'(1);
    end
  end

  assign cmd.compare = (state == S_CMP);
  assign cmd.bump    = do_bump;
  assign cmd.insert  = do_insert;
  assign cmd.key     = key_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      sbrc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left_key   (key_q),
        .left_cnt   (CNT_W'(1)),
        .left_valid (1'b0),
        .left_lt    (1'b1),
        .key_out    (c_key[i]),
        .cnt_out    (c_cnt[i]),
        .valid_out  (c_valid[i]),
        .lt_out     (c_lt[i]),
        .hit        (c_hit[i]),
        .eq_out     (c_eq[i])
      );
    end else begin : g_rest
      sbrc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left_key   (c_key[i-1]),
        .left_cnt   (c_cnt[i-1]),
        .left_valid (c_valid[i-1]),
        .left_lt    (c_lt[i-1]),
        .key_out    (c_key[i]),
        .cnt_out    (c_cnt[i]),
        .valid_out  (c_valid[i]),
        .lt_out     (c_lt[i]),
        .hit        (c_hit[i]),
        .eq_out     (c_eq[i])
      );
    end
    assign leaf[i] = c_hit[i] ? {1'b1, c_eq[i], c_cnt[i], AW'(i)} : '0;
  end

  sbrc_tree #(
    .LEAVES (N),
    .WIDTH  (NW)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tree_go),
    .leaf      (leaf),
    .out_valid (t_valid),
    .root      (t_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      tree_go <= 1'b0;
      done    <= 1'b0;
    end else begin
      tree_go <= 1'b0;
      done    <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= operation;
            key_q <= lba;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          tree_go <= 1'b1;
          state   <= S_TREE;
        end
        S_TREE: begin
          if (t_valid) begin
            used       <= used_next;
            done       <= 1'b1;
            found      <= r_found;
            use_count  <= cnt_res;
            table_full <= (op_q == OP_ADD) && !r_found && is_full;
            position   <= (32'(pos_full) > 32'(POS_MAX)) ? POS_W'(POS_MAX)
                                                         : POS_W'(pos_full);
            entry_total <= (32'(used_next) > 32'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                             : TOTAL_W'(used_next);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= 32'(N))
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> !found && (used == CW'(N)))
    else $error("table_full on a found entry or non-full table");

  a_insert_pos: assert property (@(posedge clk) disable iff (rst)
    do_insert |-> r_hit || (used != CW'(N)))
    else $error("insert with no free slot");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(state == S_TREE))
    else $error("result outside tree completion");

endmodule

`default_nettype wire

// File: hdl/sbrc_cell.sv
// ----------------------------------------------------------------------------
// sbrc_cell
// One table slot: key, count and valid flag, with its compare result.
// Shifts up from its left neighbor on an insert below it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_cell
  import sbrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_cmd_t        cmd,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic [CNT_W-1:0] left_cnt,
  input  wire logic             left_valid,
  input  wire logic             left_lt,
  output logic [KEY_W-1:0]      key_out,
  output logic [CNT_W-1:0]      cnt_out,
  output logic                  valid_out,
  output logic                  lt_out,
  output logic                  hit,
  output logic                  eq_out
);

  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] cnt;
  logic             valid;
  logic             lt;
  logic             eq;
  logic             bnd;

  // first slot not below the searched key
  assign bnd = left_lt & ~lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmd.compare) begin
        lt <= valid && (key < cmd.key);
        eq <= valid && (key == cmd.key);
      end
      if (cmd.bump && bnd) begin
        if (cnt != CNT_MAX) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.insert) begin
        if (bnd) begin
          key   <= cmd.key;
          cnt   <= CNT_W'(1);
          valid <= 1'b1;
        end else if (!lt) begin
          key   <= left_key;
          cnt   <= left_cnt;
          valid <= left_valid;
        end
      end
    end
  end

  assign key_out   = key;
  assign cnt_out   = cnt;
  assign valid_out = valid;
  assign lt_out    = lt;
  assign hit       = bnd;
  assign eq_out    = eq;

endmodule

`default_nettype wire

// File: hdl/sbrc_tree.sv
// ----------------------------------------------------------------------------
// sbrc_tree
// Pipelined OR tree that gathers the single marked leaf of the cell row.
// A register sits after every fourth level and at the root.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_tree #(
  parameter int LEAVES = 1024,
  parameter int WIDTH  = 44
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [WIDTH-1:0] leaf [LEAVES],
  output logic                  out_valid,
  output logic [WIDTH-1:0]      root
);

  localparam int LVL  = $clog2(LEAVES);
  localparam int PAD  = 1 << LVL;
  localparam int RSTG = (LVL + 3) / 4;

  logic [WIDTH-1:0] node [1:2*PAD-1];
  logic [RSTG-1:0]  vld;

  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < LEAVES) begin : g_used
      assign node[PAD+j] = leaf[j];
    end else begin : g_pad
      assign node[PAD+j] = '0;
    end
  end

  for (genvar k = 1; k < PAD; k++) begin : g_node
    localparam int H = LVL - ($clog2(k + 1) - 1);
    if ((H % 4 == 0) || (k == 1)) begin : g_reg
      logic [WIDTH-1:0] r;
      always_ff @(posedge clk) begin
        r <= node[2*k] | node[2*k+1];
      end
      assign node[k] = r;
    end else begin : g_comb
      assign node[k] = node[2*k] | node[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < RSTG; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign out_valid = vld[RSTG-1];
  assign root      = node[1];

endmodule

`default_nettype wire
